// ===== hdl/max_heap_priority_queue_core_defines.svh =====
// assertion macros for the max-heap priority queue core
// no dependencies; taken in by the top level with `include
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MHPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mhpq_pkg.sv =====
// shared types for the max-heap priority queue: steps, control word, flags
// and the microcode table; no dependencies
package mhpq_pkg;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        STS_INSERTED  = 2'd0,
        STS_EXTRACTED = 2'd1,
        STS_FULL      = 2'd2,
        STS_EMPTY     = 2'd3
    } t_status;

    // microprogram addresses
    typedef enum logic [3:0] {
        S_IDLE    = 4'd0,
        S_INS_CHK = 4'd1,
        S_INS_SET = 4'd2,
        S_UP_RD   = 4'd3,
        S_UP_CMP  = 4'd4,
        S_EXT_CHK = 4'd5,
        S_EXT_RD  = 4'd6,
        S_EXT_LD  = 4'd7,
        S_DN_RD   = 4'd8,
        S_DN_CMP  = 4'd9,
        S_PUT     = 4'd10,
        S_REJ     = 4'd11
    } t_step;

    // datapath actions
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_INS_SET,
        OP_UP_READ,
        OP_UP_MOVE,
        OP_EXT_READ,
        OP_EXT_LOAD,
        OP_DN_READ,
        OP_DN_MOVE,
        OP_PUT,
        OP_REJ
    } t_op;

    // branch conditions
    typedef enum logic [3:0] {
        T_ALWAYS,
        T_CMD_EXT,
        T_FULL,
        T_EMPTY,
        T_HOLE_ROOT,
        T_UP_STOP,
        T_DN_LEAF,
        T_DN_STOP
    } t_test;

    typedef struct packed {
        t_op   op;
        t_test test;
        logic  hold_in;
        logic  hold_out;
        t_step tgt_t;
        t_step tgt_f;
    } t_uword;

    typedef struct packed {
        logic accept;
        logic out_busy;
        logic cmd_ext;
        logic full;
        logic empty;
        logic hole_root;
        logic up_stop;
        logic dn_leaf;
        logic dn_stop;
    } t_flags;

    function automatic t_uword mk(t_op op, t_test test, logic hin, logic hout,
                                  t_step tt, t_step tf);
        t_uword w;
        w.op       = op;
        w.test     = test;
        w.hold_in  = hin;
        w.hold_out = hout;
        w.tgt_t    = tt;
        w.tgt_f    = tf;
        return w;
    endfunction

    // control store
    function automatic t_uword ucode(t_step s);
        t_uword w;
        case (s)
            S_IDLE:    w = mk(OP_LATCH,    T_CMD_EXT,   1'b1, 1'b0, S_EXT_CHK, S_INS_CHK);
            S_INS_CHK: w = mk(OP_NONE,     T_FULL,      1'b0, 1'b0, S_REJ,     S_INS_SET);
            S_INS_SET: w = mk(OP_INS_SET,  T_ALWAYS,    1'b0, 1'b0, S_UP_RD,   S_UP_RD);
            S_UP_RD:   w = mk(OP_UP_READ,  T_HOLE_ROOT, 1'b0, 1'b0, S_PUT,     S_UP_CMP);
            S_UP_CMP:  w = mk(OP_UP_MOVE,  T_UP_STOP,   1'b0, 1'b0, S_PUT,     S_UP_RD);
            S_EXT_CHK: w = mk(OP_NONE,     T_EMPTY,     1'b0, 1'b0, S_REJ,     S_EXT_RD);
            S_EXT_RD:  w = mk(OP_EXT_READ, T_ALWAYS,    1'b0, 1'b0, S_EXT_LD,  S_EXT_LD);
            S_EXT_LD:  w = mk(OP_EXT_LOAD, T_ALWAYS,    1'b0, 1'b0, S_DN_RD,   S_DN_RD);
            S_DN_RD:   w = mk(OP_DN_READ,  T_DN_LEAF,   1'b0, 1'b0, S_PUT,     S_DN_CMP);
            S_DN_CMP:  w = mk(OP_DN_MOVE,  T_DN_STOP,   1'b0, 1'b0, S_PUT,     S_DN_RD);
            S_PUT:     w = mk(OP_PUT,      T_ALWAYS,    1'b0, 1'b1, S_IDLE,    S_IDLE);
            S_REJ:     w = mk(OP_REJ,      T_ALWAYS,    1'b0, 1'b1, S_IDLE,    S_IDLE);
            default:   w = mk(OP_NONE,     T_ALWAYS,    1'b0, 1'b0, S_IDLE,    S_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/mhpq_seq.sv =====
// microcode sequencer: step register, control store lookup, branch select
// depends on mhpq_pkg
module mhpq_seq
    import mhpq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_uword o_uw
);

    t_step r_step;
    t_step n_step;
    logic  w_cond;

    assign o_uw = ucode(r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        case (o_uw.test)
            T_ALWAYS:    w_cond = 1'b1;
            T_CMD_EXT:   w_cond = i_flags.cmd_ext;
            T_FULL:      w_cond = i_flags.full;
            T_EMPTY:     w_cond = i_flags.empty;
            T_HOLE_ROOT: w_cond = i_flags.hole_root;
            T_UP_STOP:   w_cond = i_flags.up_stop;
            T_DN_LEAF:   w_cond = i_flags.dn_leaf;
            T_DN_STOP:   w_cond = i_flags.dn_stop;
            default:     w_cond = 1'b1;
        endcase
        if ((o_uw.hold_in && !i_flags.accept) || (o_uw.hold_out && i_flags.out_busy)) begin
            n_step = r_step;
        end else if (w_cond) begin
            n_step = o_uw.tgt_t;
        end else begin
            n_step = o_uw.tgt_f;
        end
    end

endmodule

// ===== hdl/max_heap_priority_queue_core.sv =====
// binary max-heap priority queue: heap memory, datapath and output register
// depends on mhpq_pkg, mhpq_seq and max_heap_priority_queue_core_defines.svh
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_cmd, i_entry_priority, i_entry_tag
//  out     | output    | o_out_valid / i_out_ready | o_status, o_out_priority,
//          |           |                           | o_out_tag, o_entry_count
//
// one word at a time; each heap level takes a read step, then a compare/move step
// insert: check for room, set the hole at the first free slot, climb, then write the entry;
// extract: check for empty, read the root and last entry, load them, sink, then write the
// moved entry; rejections go from the check straight to the result word
// synchronous active-low reset empties the heap at once; the heap memory is not cleared
// a full output register stalls only the final step; the next word is taken at idle
`include "max_heap_priority_queue_core_defines.svh"

module max_heap_priority_queue_core
    import mhpq_pkg::*;
#(
    parameter int CAPACITY      = 64,
    parameter int PRIORITY_BITS = 16,
    parameter int TAG_BITS      = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [PRIORITY_BITS-1:0]          i_entry_priority,
    input  logic [TAG_BITS-1:0]               i_entry_tag,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic [PRIORITY_BITS-1:0]          o_out_priority,
    output logic [TAG_BITS-1:0]               o_out_tag,
    output logic [$clog2(CAPACITY+1)-1:0]     o_entry_count
);

    localparam int AW = $clog2(CAPACITY);      // slot index width
    localparam int CW = $clog2(CAPACITY + 1);  // entry count width
    localparam int EW = PRIORITY_BITS + TAG_BITS;
    localparam int LW = AW + 2;                // child index width, never overflows

    // heap memory, one entry is {priority, tag}
    logic [EW-1:0] r_heap_mem [CAPACITY];
    logic [EW-1:0] r_rd_a;
    logic [EW-1:0] r_rd_b;
    logic [AW-1:0] w_ra;
    logic [AW-1:0] w_rb;
    logic          w_we;
    logic [EW-1:0] w_wd;

    // datapath registers
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_hole,  n_hole;
    logic          r_cmd,   n_cmd;
    logic [EW-1:0] r_mv,    n_mv;     // entry being sifted
    logic [EW-1:0] r_ext,   n_ext;    // extracted root

    // output register
    logic                     r_o_valid, n_o_valid;
    t_status                  r_status,  n_status;
    logic [PRIORITY_BITS-1:0] r_o_prio,  n_o_prio;
    logic [TAG_BITS-1:0]      r_o_tag,   n_o_tag;
    logic [CW-1:0]            r_o_count, n_o_count;

    // control
    t_uword uw;
    t_flags flags;
    logic   w_accept;
    logic   w_go;

    // address arithmetic and compares
    logic [AW-1:0]            w_parent;
    logic [LW-1:0]            w_left;
    logic [LW-1:0]            w_right;
    logic                     w_right_ok;
    logic                     w_take_right;
    logic [EW-1:0]            w_big;
    logic [AW-1:0]            w_big_idx;
    logic [PRIORITY_BITS-1:0] w_mv_prio;
    logic [PRIORITY_BITS-1:0] w_a_prio;
    logic [PRIORITY_BITS-1:0] w_b_prio;

    mhpq_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uw    (uw)
    );

    // no word is taken while reset is held
    assign o_in_ready = uw.hold_in && i_rst_n;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_mv_prio = r_mv[EW-1 -: PRIORITY_BITS];
    assign w_a_prio  = r_rd_a[EW-1 -: PRIORITY_BITS];
    assign w_b_prio  = r_rd_b[EW-1 -: PRIORITY_BITS];

    // parent of the hole while climbing, children while sinking
    assign w_parent     = AW'((r_hole - AW'(1)) >> 1);
    assign w_left       = {1'b0, r_hole, 1'b0} + LW'(1);
    assign w_right      = w_left + LW'(1);
    assign w_right_ok   = w_right < LW'(r_count);
    // left child wins ties
    assign w_take_right = w_right_ok && (w_b_prio > w_a_prio);
    assign w_big        = w_take_right ? r_rd_b : r_rd_a;
    assign w_big_idx    = w_take_right ? w_right[AW-1:0] : w_left[AW-1:0];

    always_comb begin
        flags.accept    = w_accept;
        flags.out_busy  = r_o_valid && !i_out_ready;
        flags.cmd_ext   = (i_cmd == CMD_EXTRACT);
        flags.full      = (r_count == CW'(CAPACITY));
        flags.empty     = (r_count == '0);
        flags.hole_root = (r_hole == '0);
        flags.up_stop   = (w_mv_prio <= w_a_prio);
        flags.dn_leaf   = (w_left >= LW'(r_count));
        flags.dn_stop   = (w_mv_prio >= w_big[EW-1 -: PRIORITY_BITS]);
    end

    // a step proceeds unless it waits for a word in or for room out
    assign w_go = !((uw.hold_in && !w_accept) || (uw.hold_out && flags.out_busy));

    // read addresses per step
    always_comb begin
        w_ra = '0;
        w_rb = '0;
        case (uw.op)
            OP_UP_READ: begin
                w_ra = w_parent;
            end
            OP_EXT_READ: begin
                w_ra = '0;
                w_rb = AW'(r_count - CW'(1));
            end
            OP_DN_READ: begin
                w_ra = w_left[AW-1:0];
                w_rb = w_right[AW-1:0];
            end
            default: begin
                w_ra = '0;
                w_rb = '0;
            end
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_hole    = r_hole;
        n_cmd     = r_cmd;
        n_mv      = r_mv;
        n_ext     = r_ext;
        n_o_valid = r_o_valid && !i_out_ready;
        n_status  = r_status;
        n_o_prio  = r_o_prio;
        n_o_tag   = r_o_tag;
        n_o_count = r_o_count;
        w_we      = 1'b0;
        w_wd      = r_mv;
        if (w_go) begin
            case (uw.op)
                OP_LATCH: begin
                    n_cmd = i_cmd;
                    n_mv  = {i_entry_priority, i_entry_tag};
                end
                OP_INS_SET: begin
                    // hole starts at the first free slot
                    n_hole  = r_count[AW-1:0];
                    n_count = r_count + CW'(1);
                end
                OP_UP_MOVE: begin
                    // parent drops into the hole, hole climbs
                    if (!flags.up_stop) begin
                        w_we   = 1'b1;
                        w_wd   = r_rd_a;
                        n_hole = w_parent;
                    end
                end
                OP_EXT_READ: begin
                    n_count = r_count - CW'(1);
                end
                OP_EXT_LOAD: begin
                    n_ext  = r_rd_a;
                    n_mv   = r_rd_b;
                    n_hole = '0;
                end
                OP_DN_MOVE: begin
                    // larger child rises into the hole, hole sinks
                    if (!flags.dn_stop) begin
                        w_we   = 1'b1;
                        w_wd   = w_big;
                        n_hole = w_big_idx;
                    end
                end
                OP_PUT: begin
                    w_we      = 1'b1;
                    w_wd      = r_mv;
                    n_o_valid = 1'b1;
                    n_o_count = r_count;
                    if (r_cmd == CMD_EXTRACT) begin
                        n_status = STS_EXTRACTED;
                        n_o_prio = r_ext[EW-1 -: PRIORITY_BITS];
                        n_o_tag  = r_ext[TAG_BITS-1:0];
                    end else begin
                        n_status = STS_INSERTED;
                        n_o_prio = '0;
                        n_o_tag  = '0;
                    end
                end
                OP_REJ: begin
                    n_o_valid = 1'b1;
                    n_o_count = r_count;
                    n_o_prio  = '0;
                    n_o_tag   = '0;
                    if (r_cmd == CMD_EXTRACT) begin
                        n_status = STS_EMPTY;
                    end else begin
                        n_status = STS_FULL;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // heap memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_heap_mem[r_hole] <= w_wd;
        end
        r_rd_a <= r_heap_mem[w_ra];
        r_rd_b <= r_heap_mem[w_rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_hole    <= n_hole;
        r_cmd     <= n_cmd;
        r_mv      <= n_mv;
        r_ext     <= n_ext;
        r_status  <= n_status;
        r_o_prio  <= n_o_prio;
        r_o_tag   <= n_o_tag;
        r_o_count <= n_o_count;
    end

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_status;
    assign o_out_priority = r_o_prio;
    assign o_out_tag      = r_o_tag;
    assign o_entry_count  = r_o_count;

    // count never passes capacity
    `MHPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "heap count above capacity")
    // taking a word leaves the count alone until the program runs
    `MHPQ_ASSERT_NEXT(a_accept_count, i_clk, i_rst_n, w_accept, $stable(r_count), "count moved on accept")
    // heap writes land inside the held entries
    `MHPQ_ASSERT_NOW(a_write_in_heap, i_clk, i_rst_n, w_we && (r_count != '0), (AW+1)'(r_hole) < (AW+1)'(r_count), "heap write beyond held entries")

endmodule

// ===== test/max_heap_priority_queue_core_checker.sv =====
// channel monitor and scoreboard for the max-heap priority queue core
// keeps its own heap copy to predict each result word; depends on mhpq_pkg
`timescale 1ns / 100ps

module max_heap_priority_queue_core_checker
    import mhpq_pkg::*;
#(
    parameter int CAPACITY      = 64,
    parameter int PRIORITY_BITS = 16,
    parameter int TAG_BITS      = 32,
    parameter int COUNT_W       = $clog2(CAPACITY + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic                     i_cmd,
    input  logic [PRIORITY_BITS-1:0] i_entry_priority,
    input  logic [TAG_BITS-1:0]      i_entry_tag,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [1:0]               i_status,
    input  logic [PRIORITY_BITS-1:0] i_out_priority,
    input  logic [TAG_BITS-1:0]      i_out_tag,
    input  logic [COUNT_W-1:0]       i_entry_count,
    output int                       o_fail_count,
    output int                       o_outstanding
);

    typedef struct packed {
        t_status                  status;
        logic [PRIORITY_BITS-1:0] prio;
        logic [TAG_BITS-1:0]      tag;
        logic [COUNT_W-1:0]       count;
    } t_queue_result;

    // shadow heap, slot 0 is the root
    logic [PRIORITY_BITS-1:0] heap_prio [CAPACITY];
    logic [TAG_BITS-1:0]      heap_tag  [CAPACITY];
    int                       heap_fill = 0;

    t_queue_result results_due [$];
    t_queue_result due_word;
    t_queue_result new_word;
    int            mismatches = 0;
    int            due_count  = 0;

    assign o_fail_count  = mismatches;
    assign o_outstanding = due_count;

    task automatic swap_slots(input int a, input int b);
        logic [PRIORITY_BITS-1:0] p;
        logic [TAG_BITS-1:0]      t;
        p = heap_prio[a];
        t = heap_tag[a];
        heap_prio[a] = heap_prio[b];
        heap_tag[a]  = heap_tag[b];
        heap_prio[b] = p;
        heap_tag[b]  = t;
    endtask

    task automatic apply_queue_op(input logic cmd, input logic [PRIORITY_BITS-1:0] prio,
                                  input logic [TAG_BITS-1:0] tag,
                                  output t_queue_result res);
        int   pos;
        int   parent;
        int   left;
        int   larger;
        logic stop;
        res  = '0;
        stop = 1'b0;
        if (cmd == CMD_INSERT) begin
            if (heap_fill >= CAPACITY) begin
                res.status = STS_FULL;
            end else begin
                pos = heap_fill;
                heap_prio[pos] = prio;
                heap_tag[pos]  = tag;
                heap_fill++;
                // climb only while strictly greater than the parent
                while (pos > 0 && !stop) begin
                    parent = (pos - 1) / 2;
                    if (heap_prio[pos] <= heap_prio[parent]) begin
                        stop = 1'b1;
                    end else begin
                        swap_slots(pos, parent);
                        pos = parent;
                    end
                end
                res.status = STS_INSERTED;
            end
        end else begin
            if (heap_fill == 0) begin
                res.status = STS_EMPTY;
            end else begin
                res.prio = heap_prio[0];
                res.tag  = heap_tag[0];
                heap_fill--;
                heap_prio[0] = heap_prio[heap_fill];
                heap_tag[0]  = heap_tag[heap_fill];
                pos = 0;
                // sink toward the larger child, left wins ties, stop when not smaller
                while (!stop) begin
                    left = 2 * pos + 1;
                    if (left >= heap_fill) begin
                        stop = 1'b1;
                    end else begin
                        larger = left;
                        if (left + 1 < heap_fill && heap_prio[left + 1] > heap_prio[left])
                            larger = left + 1;
                        if (heap_prio[pos] >= heap_prio[larger]) begin
                            stop = 1'b1;
                        end else begin
                            swap_slots(pos, larger);
                            pos = larger;
                        end
                    end
                end
                res.status = STS_EXTRACTED;
            end
        end
        res.count = COUNT_W'(heap_fill);
    endtask

    function automatic int check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            heap_fill = 0;
            results_due.delete();
            due_count <= 0;
        end else begin
            // results first: a word accepted this edge cannot have its result yet
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("result word with nothing expected: status %0d count %0d",
                           i_status, i_entry_count);
                    mismatches <= mismatches + 1;
                end else begin
                    due_word = results_due.pop_front();
                    mismatches <= mismatches
                        + check_field("status", 32'(due_word.status), 32'(i_status))
                        + check_field("out_priority", 32'(due_word.prio), 32'(i_out_priority))
                        + check_field("out_tag", 32'(due_word.tag), 32'(i_out_tag))
                        + check_field("entry_count", 32'(due_word.count), 32'(i_entry_count));
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_queue_op(i_cmd, i_entry_priority, i_entry_tag, new_word);
                results_due.push_back(new_word);
            end
            due_count <= results_due.size();
        end
    end

endmodule

// ===== test/max_heap_priority_queue_core_tb.sv =====
// stimulus and verdict for the max-heap priority queue core
// depends on mhpq_pkg, the core and max_heap_priority_queue_core_checker
`timescale 1ns / 100ps

module max_heap_priority_queue_core_tb
    import mhpq_pkg::*;
();

    localparam int CAP       = 64;
    localparam int PRIO_W    = 16;
    localparam int TAG_W     = 32;
    localparam int COUNT_W   = $clog2(CAP + 1);
    // long receiver hold-off, well past what the core can buffer
    localparam int LONG_HOLD = 300;
    // drain limit and tail after the last word
    localparam int DRAIN_GUARD = 200000;
    localparam int TAIL_CYCLES = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_cmd;
    logic [PRIO_W-1:0]  i_entry_priority;
    logic [TAG_W-1:0]   i_entry_tag;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_status;
    logic [PRIO_W-1:0]  o_out_priority;
    logic [TAG_W-1:0]   o_out_tag;
    logic [COUNT_W-1:0] o_entry_count;

    int fail_count;
    int outstanding;

    // idle percentages; the sender's is used only by the stimulus process,
    // the receiver's is handed over with nonblocking writes at the clock edge
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    // a bump of this counter asks the receiver for one long hold-off
    int hold_req_cnt  = 0;

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    max_heap_priority_queue_core #(
        .CAPACITY      (CAP),
        .PRIORITY_BITS (PRIO_W),
        .TAG_BITS      (TAG_W)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_entry_priority (i_entry_priority),
        .i_entry_tag      (i_entry_tag),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_out_priority   (o_out_priority),
        .o_out_tag        (o_out_tag),
        .o_entry_count    (o_entry_count)
    );

    max_heap_priority_queue_core_checker #(
        .CAPACITY      (CAP),
        .PRIORITY_BITS (PRIO_W),
        .TAG_BITS      (TAG_W)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_entry_priority (i_entry_priority),
        .i_entry_tag      (i_entry_tag),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_status         (o_status),
        .i_out_priority   (o_out_priority),
        .i_out_tag        (o_out_tag),
        .i_entry_count    (o_entry_count),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    // hard stop well beyond the slowest legal run (about 1.5k words, even with
    // the heaviest stalls)
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver: random back-pressure, or a long hold-off counted here
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_req_cnt != hold_seen) begin
                hold_seen = hold_req_cnt;
                hold_left = LONG_HOLD - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // offer one word after a random gap and hold it until the core takes it;
    // returns in the step of acceptance with nothing driven yet for the next step
    task automatic send_word(input logic cmd, input logic [PRIO_W-1:0] prio,
                             input logic [TAG_W-1:0] tag);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_cmd            <= cmd;
        i_entry_priority <= prio;
        i_entry_tag      <= tag;
        do
            @(posedge i_clk);
        while (!o_in_ready);
    endtask

    // sender goes quiet until every expected result word has come back
    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    // priorities: full range, a narrow band full of ties, the extremes, mid-scale
    function automatic logic [PRIO_W-1:0] pick_priority();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4)
            return PRIO_W'($urandom_range(16'hFFFF));
        else if (sel < 7)
            return PRIO_W'($urandom_range(7));
        else if (sel == 7)
            return $urandom_range(1) ? {PRIO_W{1'b1}} : {PRIO_W{1'b0}};
        else
            return PRIO_W'(16'h7FF8 + $urandom_range(15));
    endfunction

    // insert_pct steers the fill level: high drives the heap to full and past it,
    // low drains it and keeps poking at the empty heap
    task automatic run_ops(input int n_words, input int insert_pct);
        logic cmd;
        for (int k = 0; k < n_words; k++) begin
            cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
            send_word(cmd, pick_priority(), TAG_W'($urandom));
        end
    endtask

    // one sweep: fill to overflow, drain to underflow, churn mid-level,
    // then churn near empty where the heap stays shallow
    task automatic run_sweep(input logic with_hold);
        run_ops(120, 85);
        run_ops(120, 15);
        if (with_hold) begin
            // receiver blocks while the sender keeps pushing, so the input stalls
            hold_req_cnt <= hold_req_cnt + 1;
        end
        run_ops(100, 50);
        run_ops(120, 45);
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_cmd            <= CMD_INSERT;
        i_entry_priority <= '0;
        i_entry_tag      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender light, receiver heavy, with one long receiver hold-off
        src_idle_pct   = 21;
        sink_idle_pct <= 50;

        // directed: empty heap, extremes, equal priorities, drain past empty
        send_word(CMD_EXTRACT, 16'h1234, 32'h0000_0001);
        send_word(CMD_INSERT, 16'h0000, 32'h0000_0000);
        send_word(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(CMD_INSERT, 16'h8000, 32'hA5A5_A5A5);
        // equal to the root: must stay below it
        send_word(CMD_INSERT, 16'hFFFF, 32'h0000_0002);
        send_word(CMD_INSERT, 16'h8000, 32'h5A5A_5A5A);
        send_word(CMD_INSERT, 16'h0001, 32'h8000_0000);
        send_word(CMD_INSERT, 16'h8000, 32'h0000_0003);
        send_word(CMD_INSERT, 16'h7FFF, 32'h7FFF_FFFF);
        // extracts walk the tie rules of the sift-down
        repeat (8) send_word(CMD_EXTRACT, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(CMD_EXTRACT, 16'h0000, 32'h0000_0000);
        send_word(CMD_INSERT, 16'h5555, 32'h1234_5678);
        send_word(CMD_EXTRACT, 16'hAAAA, 32'hDEAD_BEEF);
        pause_until_drained();

        run_sweep(1'b1);
        pause_until_drained();

        // roles swapped; pause once more with a partly filled heap
        src_idle_pct   = 50;
        sink_idle_pct <= 21;
        run_ops(60, 85);
        pause_until_drained();
        run_sweep(1'b0);
        pause_until_drained();

        // no idling on either side
        src_idle_pct   = 0;
        sink_idle_pct <= 0;
        run_sweep(1'b0);

        i_in_valid <= 1'b0;
        for (int guard = 0; guard < DRAIN_GUARD && outstanding != 0; guard++)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (outstanding != 0)
            $error("%0d result words never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mhpq_pkg.sv
hdl/mhpq_seq.sv
hdl/max_heap_priority_queue_core.sv
test/max_heap_priority_queue_core_checker.sv
test/max_heap_priority_queue_core_tb.sv
